[design/u8dw_pkg.sv]
package u8dw_pkg;

    localparam int SUM_BITS = 16;
    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } req_word_t;

    typedef struct packed {
        logic [15:0] total_width;
        logic        saturated;
    } rsp_word_t;

    // width to add for one byte step, and end-of-string mark
    typedef struct packed {
        logic [1:0] width;
        logic       last;
    } width_evt_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0)
        begin
            len = 3'd1;
        end
        else if (b[7:5] == 3'b110)
        begin
            len = 3'd2;
        end
        else if (b[7:4] == 4'b1110)
        begin
            len = 3'd3;
        end
        else if (b[7:3] == 5'b11110)
        begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] len);
        logic [20:0] cp;
        case (len)
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: cp = {13'd0, b0};
        endcase
        return cp;
    endfunction

    function automatic logic [1:0] cp_width(input logic [20:0] cp);
        logic [1:0] w;
        if (cp < 21'h20 || cp inside {[21'h7F:21'h9F]})
        begin
            w = 2'd0;
        end
        else if (cp inside {[21'h0300:21'h036F], [21'h1AB0:21'h1AFF], [21'h1DC0:21'h1DFF],
                            [21'h20D0:21'h20FF], [21'hFE20:21'hFE2F]})
        begin
            w = 2'd0;
        end
        else if (cp inside {[21'h1100:21'h115F], 21'h2329, 21'h232A,
                            [21'h2E80:21'h303E], [21'h3040:21'hA4CF],
                            [21'hAC00:21'hD7A3], [21'hF900:21'hFAFF],
                            [21'hFE10:21'hFE19], [21'hFE30:21'hFE6F],
                            [21'hFF00:21'hFF60], [21'hFFE0:21'hFFE6],
                            [21'h1F300:21'h1FAFF], [21'h20000:21'h3FFFD]})
        begin
            w = 2'd2;
        end
        else
        begin
            w = 2'd1;
        end
        return w;
    endfunction

    // width of a byte scored alone as a lead
    function automatic logic [1:0] single_width(input logic [7:0] b);
        logic [1:0] w;
        if (lead_length(b) == 3'd1)
        begin
            w = cp_width({13'd0, b});
        end
        else
        begin
            w = cp_width(REPLACEMENT_CP);
        end
        return w;
    endfunction

endpackage

[design/u8dw_front.sv]
module u8dw_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  u8dw_pkg::req_word_t   req_word,
    output logic                  evt_valid,
    input  logic                  evt_ready,
    output u8dw_pkg::width_evt_t  evt_word
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] seq_reg, seq_next;

    logic [7:0] seq_b [4];
    logic [7:0] b;
    logic       last;
    logic [2:0] len;
    logic [1:0] w;
    logic [1:0] tail_w;
    logic       accept;

    assign b         = req_word.data_byte;
    assign last      = req_word.last_byte;
    assign req_ready = evt_ready;
    assign accept    = req_valid && evt_ready;
    assign len       = u8dw_pkg::lead_length(b);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            seq_b[i] = held_reg[i];
        end
        seq_b[3] = 8'd0;
        seq_b[cnt_reg] = b;
    end

    // rescoring of a truncated tail, lead already counted
    always_comb
    begin
        if (cnt_reg == 2'd1)
        begin
            tail_w = u8dw_pkg::single_width(b);
        end
        else if (u8dw_pkg::lead_length(held_reg[1]) == 3'd2)
        begin
            tail_w = u8dw_pkg::cp_width(u8dw_pkg::assemble(held_reg[1], b, 8'd0, 8'd0, 3'd2));
        end
        else
        begin
            tail_w = 2'(u8dw_pkg::single_width(held_reg[1]) + u8dw_pkg::single_width(b));
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            held_next[i] = held_reg[i];
        end
        cnt_next = cnt_reg;
        seq_next = seq_reg;
        w        = 2'd0;
        if (seq_reg == 3'd0)
        begin
            if (len == 3'd0)
            begin
                w = u8dw_pkg::cp_width(u8dw_pkg::REPLACEMENT_CP);
            end
            else if (len == 3'd1)
            begin
                w = u8dw_pkg::cp_width({13'd0, b});
            end
            else if (last)
            begin
                w = u8dw_pkg::cp_width(u8dw_pkg::REPLACEMENT_CP);
            end
            else
            begin
                held_next[0] = b;
                cnt_next     = 2'd1;
                seq_next     = len;
            end
        end
        else
        begin
            if (({1'b0, cnt_reg} + 3'd1) >= seq_reg)
            begin
                w = u8dw_pkg::cp_width(u8dw_pkg::assemble(seq_b[0], seq_b[1], seq_b[2],
                                                          seq_b[3], seq_reg));
                cnt_next = 2'd0;
                seq_next = 3'd0;
            end
            else if (last)
            begin
                w = 2'(u8dw_pkg::cp_width(u8dw_pkg::REPLACEMENT_CP) + tail_w);
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cnt_reg == 2'(i))
                    begin
                        held_next[i] = b;
                    end
                end
                cnt_next = cnt_reg + 2'd1;
            end
        end
        if (last)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_next[i] = 8'd0;
            end
            cnt_next = 2'd0;
            seq_next = 3'd0;
        end
    end

    assign evt_valid      = req_valid && (w != 2'd0 || last);
    assign evt_word.width = w;
    assign evt_word.last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_reg[i] <= 8'd0;
            end
            cnt_reg <= 2'd0;
            seq_reg <= 3'd0;
        end
        else if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_reg[i] <= held_next[i];
            end
            cnt_reg <= cnt_next;
            seq_reg <= seq_next;
        end
    end

endmodule

[design/u8dw_queue.sv]
module u8dw_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  u8dw_pkg::width_evt_t  push_word,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output u8dw_pkg::width_evt_t  pop_word
);

    u8dw_pkg::width_evt_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_word   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/u8dw_back.sv]
module u8dw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  evt_valid,
    output logic                  evt_ready,
    input  u8dw_pkg::width_evt_t  evt_word,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output u8dw_pkg::rsp_word_t   rsp_word
);

    localparam int SB = u8dw_pkg::SUM_BITS;
    localparam logic [SB:0] SUM_MAX = {1'b0, {SB{1'b1}}};

    logic [SB-1:0]       sum_reg, sum_next;
    logic                sat_reg, sat_next;
    logic                rsp_valid_reg, rsp_valid_next;
    u8dw_pkg::rsp_word_t rsp_word_reg, rsp_word_next;
    logic [SB:0]         add;
    logic                pop;

    assign evt_ready = !evt_word.last || !rsp_valid_reg || rsp_ready;
    assign pop       = evt_valid && evt_ready;
    assign add       = {1'b0, sum_reg} + (SB + 1)'(evt_word.width);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_comb
    begin
        logic [SB-1:0] s;
        logic          f;
        s              = sum_reg;
        f              = sat_reg;
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (pop)
        begin
            if (add >= SUM_MAX)
            begin
                s = SUM_MAX[SB-1:0];
                f = 1'b1;
            end
            else
            begin
                s = add[SB-1:0];
            end
            if (evt_word.last)
            begin
                rsp_word_next.total_width = 16'(s);
                rsp_word_next.saturated   = f;
                rsp_valid_next            = 1'b1;
                sum_next                  = '0;
                sat_next                  = 1'b0;
            end
            else
            begin
                sum_next = s;
                sat_next = f;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[design/utf8_display_width.sv]
// Terminal display width of a UTF-8 string.
// req channel: one string byte per word (data_byte), last_byte set on the
// final byte. rsp channel: one word per string with the summed width and a
// saturation flag. Both channels use valid/ready.
// Throughput: one byte per cycle while the queue has room. The front
// decoder classifies each byte in the cycle it is accepted and pushes a
// width word into a 2-entry queue for a nonzero width or the last byte;
// the back accumulator drains one word per cycle unless a last word waits
// on a stalled rsp. Results pass the queue, then the output register.
// When rsp stalls, the result is held in the output register and the back
// keeps adding widths of the next string; it stops only on that string's
// last word, and the front stops taking bytes once the queue is full.
// Reset clears the decoder, the queue, the accumulator and the output valid;
// no initialization time is needed.
module utf8_display_width (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  u8dw_pkg::req_word_t  req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output u8dw_pkg::rsp_word_t  rsp_word
);

    logic                 fq_valid, fq_ready;
    u8dw_pkg::width_evt_t fq_word;
    logic                 qb_valid, qb_ready;
    u8dw_pkg::width_evt_t qb_word;

    u8dw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .evt_valid (fq_valid),
        .evt_ready (fq_ready),
        .evt_word  (fq_word)
    );

    u8dw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_word  (fq_word),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_word   (qb_word)
    );

    u8dw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (qb_valid),
        .evt_ready (qb_ready),
        .evt_word  (qb_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

endmodule
